// ===== design/spherical_shell_normaliser_top_defines.svh =====
// assertion macros for the spherical shell normaliser
`ifndef SPHERICAL_SHELL_NORMALISER_TOP_DEFINES_SVH
`define SPHERICAL_SHELL_NORMALISER_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define SSN_ASSERT_IMP(lbl, cond, conseq, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) else $error(msg);
`define SSN_ASSERT_NXT(lbl, cond, conseq, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) else $error(msg);
`else
`define SSN_ASSERT_IMP(lbl, cond, conseq, msg)
`define SSN_ASSERT_NXT(lbl, cond, conseq, msg)
`endif

`endif

// ===== design/ssn_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssn_pkg
// Types, constants and helper functions of the spherical shell normaliser.
// ----------------------------------------------------------------------------
package ssn_pkg;

  localparam int CentreW = 24;
  localparam int DataW   = 32;
  localparam int EdgeW   = 26;
  localparam int CubeW   = 80;
  localparam int AccW    = 113;
  localparam int MplW    = 35;
  localparam int CntW    = 6;
  localparam int NumShift = 39;

  localparam logic [MplW-1:0] VolK = 35'd17990716939;

  localparam logic signed [EdgeW+1:0] EdgeMax = 28'sd33554431;
  localparam logic signed [EdgeW+1:0] EdgeMin = -28'sd33554432;

  localparam logic [DataW-1:0] SatPos = 32'h7FFF_FFFF;
  localparam logic [DataW-1:0] SatNeg = 32'h8000_0000;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_OUTER,
    ST_SQ,
    ST_CB,
    ST_CSIGN,
    ST_DIFF,
    ST_DABS,
    ST_DEN,
    ST_DCHK,
    ST_DIV,
    ST_QSAT,
    ST_PUSH
  } state_t;

  typedef struct packed {
    logic [DataW-1:0] norm_value;
    logic [DataW-1:0] norm_error;
    logic             zero_volume;
    logic             end_of_sequence;
  } res_t;

  function automatic logic [EdgeW-1:0] sat_edge(input logic signed [EdgeW+1:0] e);
    logic [EdgeW-1:0] r;
    if (e > EdgeMax) begin
      r = EdgeMax[EdgeW-1:0];
    end else if (e < EdgeMin) begin
      r = EdgeMin[EdgeW-1:0];
    end else begin
      r = e[EdgeW-1:0];
    end
    return r;
  endfunction

  function automatic logic [EdgeW-1:0] edge_mag(input logic [EdgeW-1:0] e);
    return e[EdgeW-1] ? (~e + 1'b1) : e;
  endfunction

  function automatic logic [DataW:0] data_mag(input logic [DataW-1:0] raw);
    logic [DataW-1:0] n;
    n = ~raw + 1'b1;
    return raw[DataW-1] ? {1'b0, n} : {1'b0, raw};
  endfunction

  function automatic logic [DataW-1:0] sat_zero(input logic [DataW-1:0] raw);
    logic [DataW-1:0] r;
    if (raw == '0) begin
      r = '0;
    end else if (raw[DataW-1]) begin
      r = SatNeg;
    end else begin
      r = SatPos;
    end
    return r;
  endfunction

  function automatic logic [DataW-1:0] sat_quot(input logic [DataW-1:0] q,
                                                input logic ovf, input logic neg);
    logic [DataW-1:0] r;
    if (neg) begin
      r = (ovf || q > SatNeg) ? SatNeg : (~q + 1'b1);
    end else begin
      r = (ovf || q[DataW-1]) ? SatPos : q;
    end
    return r;
  endfunction

endpackage

// ===== design/ssn_addsub.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssn_addsub
// Shared wide adder/subtractor used for multiply, negate and divide steps.
// ----------------------------------------------------------------------------
module ssn_addsub (
  input  logic [ssn_pkg::AccW-1:0] a,
  input  logic [ssn_pkg::AccW-1:0] b,
  input  logic                     sub,
  output logic [ssn_pkg::AccW-1:0] sum,
  output logic                     carry
);

  logic [ssn_pkg::AccW-1:0] b_eff;
  logic [ssn_pkg::AccW:0]   total;

  assign b_eff = sub ? ~b : b;
  assign total = {1'b0, a} + {1'b0, b_eff} + {{ssn_pkg::AccW{1'b0}}, sub};
  assign sum   = total[ssn_pkg::AccW-1:0];
  assign carry = total[ssn_pkg::AccW];

endmodule

// ===== design/ssn_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssn_core
// Sequencer and datapath: edges, cubes, shell volume and quotients computed
// bit-serially on one shared adder.
// ----------------------------------------------------------------------------
module ssn_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          errors_present,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [ssn_pkg::CentreW-1:0]   in_centre,
  input  logic [ssn_pkg::DataW-1:0]     in_value,
  input  logic [ssn_pkg::DataW-1:0]     in_error,
  input  logic                          in_first,
  input  logic                          in_last,
  output logic                          res_valid,
  input  logic                          res_ready,
  output ssn_pkg::res_t                 res
);

  localparam int AccW  = ssn_pkg::AccW;
  localparam int EdgeW = ssn_pkg::EdgeW;
  localparam int CubeW = ssn_pkg::CubeW;
  localparam int DataW = ssn_pkg::DataW;
  localparam int CntW  = ssn_pkg::CntW;
  localparam int MplW  = ssn_pkg::MplW;
  localparam logic [CntW-1:0] MagLast = CntW'(EdgeW - 1);
  localparam logic [CntW-1:0] KLast   = CntW'(MplW - 1);
  localparam logic [CntW-1:0] QLast   = CntW'(DataW - 1);

  ssn_pkg::state_t state, state_next;

  logic [1:0]                 pos;
  logic                       emit_held;
  logic                       cube_inner;
  logic                       div_err;

  logic [ssn_pkg::CentreW-1:0] held_centre, cur_centre;
  logic [DataW-1:0]           held_value, held_error, cur_value, cur_error;
  logic                       cur_last;
  logic [EdgeW-1:0]           inner_edge, edge_r;
  logic [CubeW-1:0]           inner_cubed, outer_cubed;
  logic [AccW-1:0]            acc, mcand;
  logic [MplW-1:0]            mplier;
  logic [CntW-1:0]            cnt;
  logic [DataW-1:0]           q;
  logic                       ovf, d_neg;
  logic [DataW-1:0]           r_value, r_error;
  logic                       r_zero;

  logic                       accept;
  logic [ssn_pkg::CentreW-1:0] sel_centre;
  logic [DataW-1:0]           sel_value, sel_error;
  logic signed [EdgeW+1:0]    edge_raw;
  logic [EdgeW-1:0]           edge_new, mag_new, mag_r;
  logic [AccW-1:0]            acc_shl, op_a, op_b, sum;
  logic                       op_sub, carry, neg_src;

  assign accept     = in_valid && in_ready;
  assign sel_centre = emit_held ? held_centre : cur_centre;
  assign sel_value  = emit_held ? held_value : cur_value;
  assign sel_error  = emit_held ? held_error : cur_error;
  assign acc_shl    = {acc[AccW-2:0], 1'b0};

  // inner edge from the first two centres, else outer edge from the inner one
  always_comb begin
    if (state == ssn_pkg::ST_IDLE) begin
      edge_raw = $signed({4'b0, held_centre}) + $signed({3'b0, held_centre, 1'b0})
                 - $signed({4'b0, in_centre});
    end else begin
      edge_raw = $signed({2'b0, sel_centre, 2'b0})
                 - $signed({{2{inner_edge[EdgeW-1]}}, inner_edge});
    end
  end

  assign edge_new = ssn_pkg::sat_edge(edge_raw);
  assign mag_new  = ssn_pkg::edge_mag(edge_new);
  assign mag_r    = ssn_pkg::edge_mag(edge_r);

  always_comb begin
    op_a    = acc;
    op_b    = '0;
    op_sub  = 1'b0;
    neg_src = (state == ssn_pkg::ST_CSIGN) ? edge_r[EdgeW-1] : acc[AccW-1];
    unique case (state)
      ssn_pkg::ST_SQ, ssn_pkg::ST_CB, ssn_pkg::ST_DEN: begin
        op_a = acc_shl;
        op_b = mplier[MplW-1] ? mcand : '0;
      end
      ssn_pkg::ST_CSIGN, ssn_pkg::ST_DABS: begin
        op_a   = neg_src ? '0 : acc;
        op_b   = neg_src ? acc : '0;
        op_sub = neg_src;
      end
      ssn_pkg::ST_DIFF: begin
        op_a   = {{(AccW-CubeW){outer_cubed[CubeW-1]}}, outer_cubed};
        op_b   = {{(AccW-CubeW){inner_cubed[CubeW-1]}}, inner_cubed};
        op_sub = 1'b1;
      end
      ssn_pkg::ST_DCHK: begin
        op_b   = mcand;
        op_sub = 1'b1;
      end
      ssn_pkg::ST_DIV: begin
        op_a   = acc_shl;
        op_b   = mcand;
        op_sub = 1'b1;
      end
      default: begin
        op_a = acc;
      end
    endcase
  end

  ssn_addsub u_addsub (
    .a     (op_a),
    .b     (op_b),
    .sub   (op_sub),
    .sum   (sum),
    .carry (carry)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ssn_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (in_first) begin
            state_next = in_last ? ssn_pkg::ST_PUSH : ssn_pkg::ST_IDLE;
          end else if (pos == 2'd1) begin
            state_next = ssn_pkg::ST_SQ;
          end else if (pos == 2'd2) begin
            state_next = ssn_pkg::ST_OUTER;
          end
        end
      end
      ssn_pkg::ST_OUTER: state_next = ssn_pkg::ST_SQ;
      ssn_pkg::ST_SQ:    if (cnt == '0) state_next = ssn_pkg::ST_CB;
      ssn_pkg::ST_CB:    if (cnt == '0) state_next = ssn_pkg::ST_CSIGN;
      ssn_pkg::ST_CSIGN: state_next = cube_inner ? ssn_pkg::ST_OUTER : ssn_pkg::ST_DIFF;
      ssn_pkg::ST_DIFF:  state_next = (sum == '0) ? ssn_pkg::ST_PUSH : ssn_pkg::ST_DABS;
      ssn_pkg::ST_DABS:  state_next = ssn_pkg::ST_DEN;
      ssn_pkg::ST_DEN:   if (cnt == '0) state_next = ssn_pkg::ST_DCHK;
      ssn_pkg::ST_DCHK:  state_next = carry ? ssn_pkg::ST_QSAT : ssn_pkg::ST_DIV;
      ssn_pkg::ST_DIV:   if (cnt == '0) state_next = ssn_pkg::ST_QSAT;
      ssn_pkg::ST_QSAT: begin
        state_next = (!div_err && errors_present) ? ssn_pkg::ST_DCHK : ssn_pkg::ST_PUSH;
      end
      ssn_pkg::ST_PUSH: begin
        if (res_ready) begin
          state_next = emit_held ? ssn_pkg::ST_OUTER : ssn_pkg::ST_IDLE;
        end
      end
      default: state_next = ssn_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready            = (state == ssn_pkg::ST_IDLE);
    res_valid           = (state == ssn_pkg::ST_PUSH);
    res.norm_value      = r_value;
    res.norm_error      = r_error;
    res.zero_volume     = r_zero;
    res.end_of_sequence = !emit_held && cur_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ssn_pkg::ST_IDLE;
      pos        <= 2'd0;
      emit_held  <= 1'b0;
      cube_inner <= 1'b0;
      div_err    <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        if (in_first) begin
          pos       <= in_last ? 2'd0 : 2'd1;
          emit_held <= 1'b0;
        end else if (pos != 2'd0) begin
          pos        <= in_last ? 2'd0 : 2'd2;
          emit_held  <= (pos == 2'd1);
          cube_inner <= (pos == 2'd1);
        end
      end
      if (state == ssn_pkg::ST_OUTER) begin
        cube_inner <= 1'b0;
      end
      if (state == ssn_pkg::ST_DEN) begin
        div_err <= 1'b0;
      end
      if (state == ssn_pkg::ST_QSAT) begin
        div_err <= 1'b1;
      end
      if (state == ssn_pkg::ST_PUSH && res_ready) begin
        emit_held <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ssn_pkg::ST_IDLE: begin
        if (accept) begin
          cur_centre <= in_centre;
          cur_value  <= in_value;
          cur_error  <= in_error;
          cur_last   <= in_last;
          if (in_first) begin
            held_centre <= in_centre;
            held_value  <= in_value;
            held_error  <= in_error;
            r_value     <= in_value;
            r_error     <= in_error;
            r_zero      <= 1'b0;
          end else begin
            edge_r <= edge_new;
            acc    <= '0;
            mcand  <= {{(AccW-EdgeW){1'b0}}, mag_new};
            mplier <= {mag_new, {(MplW-EdgeW){1'b0}}};
            cnt    <= MagLast;
          end
        end
      end
      ssn_pkg::ST_OUTER: begin
        edge_r <= edge_new;
        acc    <= '0;
        mcand  <= {{(AccW-EdgeW){1'b0}}, mag_new};
        mplier <= {mag_new, {(MplW-EdgeW){1'b0}}};
        cnt    <= MagLast;
      end
      ssn_pkg::ST_SQ: begin
        acc    <= sum;
        mplier <= {mplier[MplW-2:0], 1'b0};
        cnt    <= cnt - 1'b1;
        if (cnt == '0) begin
          mcand  <= sum;
          acc    <= '0;
          mplier <= {mag_r, {(MplW-EdgeW){1'b0}}};
          cnt    <= MagLast;
        end
      end
      ssn_pkg::ST_CB: begin
        acc    <= sum;
        mplier <= {mplier[MplW-2:0], 1'b0};
        cnt    <= cnt - 1'b1;
      end
      ssn_pkg::ST_CSIGN: begin
        if (cube_inner) begin
          inner_edge  <= edge_r;
          inner_cubed <= sum[CubeW-1:0];
        end else begin
          outer_cubed <= sum[CubeW-1:0];
        end
      end
      ssn_pkg::ST_DIFF: begin
        acc         <= sum;
        r_zero      <= (sum == '0);
        inner_edge  <= edge_r;
        inner_cubed <= outer_cubed;
        r_value     <= ssn_pkg::sat_zero(sel_value);
        r_error     <= errors_present ? ssn_pkg::sat_zero(sel_error) : sel_error;
      end
      ssn_pkg::ST_DABS: begin
        d_neg  <= acc[AccW-1];
        mcand  <= sum;
        acc    <= '0;
        mplier <= ssn_pkg::VolK;
        cnt    <= KLast;
      end
      ssn_pkg::ST_DEN: begin
        acc    <= sum;
        mplier <= {mplier[MplW-2:0], 1'b0};
        cnt    <= cnt - 1'b1;
        if (cnt == '0) begin
          mcand <= sum;
          acc   <= {{(AccW-DataW-1-ssn_pkg::NumShift){1'b0}},
                    ssn_pkg::data_mag(sel_value), {ssn_pkg::NumShift{1'b0}}};
        end
      end
      ssn_pkg::ST_DCHK: begin
        ovf <= carry;
        q   <= '0;
        cnt <= QLast;
      end
      ssn_pkg::ST_DIV: begin
        acc <= carry ? sum : acc_shl;
        q   <= {q[DataW-2:0], carry};
        cnt <= cnt - 1'b1;
      end
      ssn_pkg::ST_QSAT: begin
        if (!div_err) begin
          r_value <= ssn_pkg::sat_quot(q, ovf, sel_value[DataW-1] ^ d_neg);
          if (errors_present) begin
            acc <= {{(AccW-DataW-1-ssn_pkg::NumShift){1'b0}},
                    ssn_pkg::data_mag(sel_error), {ssn_pkg::NumShift{1'b0}}};
          end else begin
            r_error <= sel_error;
          end
        end else begin
          r_error <= ssn_pkg::sat_quot(q, ovf, sel_error[DataW-1] ^ d_neg);
        end
      end
      default: begin
        acc <= acc;
      end
    endcase
  end

endmodule

// ===== design/spherical_shell_normaliser_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spherical_shell_normaliser_top
// Divides histogram bin values and errors by their spherical shell volume.
// ----------------------------------------------------------------------------
// results: a zero shell volume skips the divider; a sequence's second bin gives
//   two results
// throughput: one item at a time; the bit-serial shift-add multiplier and
//   restoring divider share one 113-bit adder
// reset: synchronous rst clears sequencer, sequence position and errors_present
// ----------------------------------------------------------------------------
`include "spherical_shell_normaliser_top_defines.svh"

module spherical_shell_normaliser_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,    // errors_present
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [87:0] s_axis_tdata,   // bin_centre, bin_value, bin_error
  input  logic        s_axis_tuser,   // first_bin
  input  logic        s_axis_tlast,   // last_bin
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // norm_value, norm_error
  output logic        m_axis_tuser,   // zero_volume
  output logic        m_axis_tlast    // end_of_sequence
);

  logic          errors_present;
  logic          res_valid;
  logic          res_ready;
  ssn_pkg::res_t res;
  ssn_pkg::res_t out_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      errors_present <= 1'b0;
    end else if (cfg_wr_en) begin
      errors_present <= cfg_wr_data;
    end
  end

  ssn_core u_core (
    .clk            (clk),
    .rst            (rst),
    .errors_present (errors_present),
    .in_valid       (s_axis_tvalid),
    .in_ready       (s_axis_tready),
    .in_centre      (s_axis_tdata[23:0]),
    .in_value       (s_axis_tdata[55:24]),
    .in_error       (s_axis_tdata[87:56]),
    .in_first       (s_axis_tuser),
    .in_last        (s_axis_tlast),
    .res_valid      (res_valid),
    .res_ready      (res_ready),
    .res            (res)
  );

  assign res_ready = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_axis_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res <= res;
    end
  end

  assign m_axis_tdata = {out_res.norm_error, out_res.norm_value};
  assign m_axis_tuser = out_res.zero_volume;
  assign m_axis_tlast = out_res.end_of_sequence;

  `SSN_ASSERT_IMP(a_no_overwrite, res_valid && m_axis_tvalid && !m_axis_tready, !res_ready, "result would overwrite an item not yet taken")
  `SSN_ASSERT_IMP(a_zero_vol_sat, m_axis_tvalid && m_axis_tuser, m_axis_tdata[31:0] == 32'h0 || m_axis_tdata[31:0] == 32'h7FFF_FFFF || m_axis_tdata[31:0] == 32'h8000_0000, "zero volume result not saturated")
  `SSN_ASSERT_NXT(a_pass_busy, s_axis_tvalid && s_axis_tready && s_axis_tuser && s_axis_tlast, !s_axis_tready, "single bin item did not hold off input")

endmodule
